### rtl/hslp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_pkg
// Types and constants shared by the status line parser.
// ----------------------------------------------------------------------------
package hslp_pkg;

  localparam int unsigned POS_W  = 17;
  localparam int unsigned CODE_W = 10;

  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [10:0] {
    PH_H1         = 11'b000_0000_0001,
    PH_T1         = 11'b000_0000_0010,
    PH_T2         = 11'b000_0000_0100,
    PH_P          = 11'b000_0000_1000,
    PH_AFTER_HTTP = 11'b000_0001_0000,
    PH_MAJOR      = 11'b000_0010_0000,
    PH_MINOR      = 11'b000_0100_0000,
    PH_SKIP       = 11'b000_1000_0000,
    PH_CODE       = 11'b001_0000_0000,
    PH_MSG        = 11'b010_0000_0000,
    PH_BAD        = 11'b100_0000_0000
  } phase_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

### rtl/http_status_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_status_line_parser
// Parses an HTTP status line one byte per transaction and reports the
// status code and the trimmed message offsets on the last byte.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in_     | valid, stall, line_byte, last_byte      | sink
//  out_    | valid, stall, status_valid, status_code,| source
//          | message_start, message_end              |
//
//  one byte per clock while in_stall is low; a byte passes an input register
//  and the parser logic, and a result is then held in the result register
//  synchronous active-low reset returns the parser to expect the letter H
//  out_stall holds the result register; non-last bytes keep flowing until a
//  last byte finds the result register still occupied
// ----------------------------------------------------------------------------
module http_status_line_parser #(
  parameter int unsigned MAX_LINE = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_line_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status_valid,
  output logic [hslp_pkg::CODE_W-1:0] out_status_code,
  output logic [hslp_pkg::POS_W-1:0]  out_message_start,
  output logic [hslp_pkg::POS_W-1:0]  out_message_end
);

  localparam logic [hslp_pkg::POS_W-1:0] MaxLine = hslp_pkg::POS_W'(MAX_LINE);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parser state
  hslp_pkg::phase_t            phase_r, phase_nxt, phase_cur;
  logic [hslp_pkg::CODE_W-1:0] acc_r, acc_nxt;
  logic [1:0]                  dseen_r, dseen_nxt;
  logic [hslp_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [hslp_pkg::POS_W-1:0]  first_r, first_nxt;
  logic [hslp_pkg::POS_W-1:0]  lend_r, lend_nxt;
  logic                        started_r, started_nxt;

  // result register
  logic                        out_valid_r;
  logic                        res_ok_r;
  logic [hslp_pkg::CODE_W-1:0] res_code_r;
  logic [hslp_pkg::POS_W-1:0]  res_start_r;
  logic [hslp_pkg::POS_W-1:0]  res_end_r;

  logic                        out_free, fire, in_take;
  logic                        c_dig, c_sp;
  logic [hslp_pkg::CODE_W-1:0] c_val;
  hslp_pkg::phase_t            bc_phase;
  logic [hslp_pkg::POS_W-1:0]  pos_inc;
  logic [hslp_pkg::CODE_W-1:0] acc_mul;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  assign c_dig   = hslp_pkg::is_digit(s1_byte_r);
  assign c_sp    = hslp_pkg::is_space(s1_byte_r);
  assign c_val   = hslp_pkg::CODE_W'(s1_byte_r - hslp_pkg::CH_ZERO);
  assign pos_inc = pos_r + 1'b1;
  assign acc_mul = (acc_r << 3) + (acc_r << 1) + c_val;

  // where whitespace or the first status digit may come
  always_comb begin
    if (c_sp) begin
      bc_phase = hslp_pkg::PH_SKIP;
    end else if (c_dig) begin
      bc_phase = hslp_pkg::PH_CODE;
    end else begin
      bc_phase = hslp_pkg::PH_BAD;
    end
  end

  always_comb begin
    phase_cur   = (pos_r >= MaxLine) ? hslp_pkg::PH_BAD : phase_r;
    pos_nxt     = (pos_r >= MaxLine) ? pos_r : pos_inc;
    phase_nxt   = phase_cur;
    acc_nxt     = acc_r;
    dseen_nxt   = dseen_r;
    first_nxt   = first_r;
    lend_nxt    = lend_r;
    started_nxt = started_r;

    case (phase_cur)
      hslp_pkg::PH_H1: begin
        phase_nxt = (s1_byte_r == hslp_pkg::CH_H) ? hslp_pkg::PH_T1 : hslp_pkg::PH_BAD;
      end
      hslp_pkg::PH_T1: begin
        phase_nxt = (s1_byte_r == hslp_pkg::CH_T) ? hslp_pkg::PH_T2 : hslp_pkg::PH_BAD;
      end
      hslp_pkg::PH_T2: begin
        phase_nxt = (s1_byte_r == hslp_pkg::CH_T) ? hslp_pkg::PH_P : hslp_pkg::PH_BAD;
      end
      hslp_pkg::PH_P: begin
        phase_nxt = (s1_byte_r == hslp_pkg::CH_P) ? hslp_pkg::PH_AFTER_HTTP
                                                  : hslp_pkg::PH_BAD;
      end
      hslp_pkg::PH_AFTER_HTTP: begin
        if (s1_byte_r == hslp_pkg::CH_SLASH) begin
          phase_nxt = hslp_pkg::PH_MAJOR;
        end else begin
          phase_nxt = bc_phase;
          if (c_dig) begin
            acc_nxt   = c_val;
            dseen_nxt = 2'd1;
          end
        end
      end
      hslp_pkg::PH_MAJOR: begin
        if (c_dig) begin
          phase_nxt = hslp_pkg::PH_MAJOR;
        end else if (s1_byte_r == hslp_pkg::CH_DOT) begin
          phase_nxt = hslp_pkg::PH_MINOR;
        end else begin
          phase_nxt = bc_phase;
        end
      end
      hslp_pkg::PH_MINOR: begin
        phase_nxt = c_dig ? hslp_pkg::PH_MINOR : bc_phase;
      end
      hslp_pkg::PH_SKIP: begin
        phase_nxt = c_sp ? hslp_pkg::PH_SKIP : bc_phase;
        if (c_dig) begin
          acc_nxt   = c_val;
          dseen_nxt = 2'd1;
        end
      end
      hslp_pkg::PH_CODE: begin
        if (c_dig) begin
          acc_nxt   = acc_mul;
          dseen_nxt = dseen_r + 2'd1;
          phase_nxt = (dseen_r == 2'd2) ? hslp_pkg::PH_MSG : hslp_pkg::PH_CODE;
        end else begin
          phase_nxt = hslp_pkg::PH_BAD;
        end
      end
      hslp_pkg::PH_MSG: begin
        if (!c_sp) begin
          if (!started_r) begin
            first_nxt   = pos_r;
            started_nxt = 1'b1;
          end
          lend_nxt = pos_inc;
        end
      end
      default: begin
        phase_nxt = hslp_pkg::PH_BAD;
      end
    endcase
  end

  // the digit runs of the version leave acc untouched: acc is only loaded
  // when a digit opens the code from AFTER_HTTP or SKIP, which never happens
  // inside MAJOR or MINOR since digits stay in those phases

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= hslp_pkg::PH_H1;
      acc_r       <= '0;
      dseen_r     <= '0;
      pos_r       <= '0;
      first_r     <= '0;
      lend_r      <= '0;
      started_r   <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end

      if (fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (fire) begin
        if (s1_last_r) begin
          phase_r   <= hslp_pkg::PH_H1;
          acc_r     <= '0;
          dseen_r   <= '0;
          pos_r     <= '0;
          first_r   <= '0;
          lend_r    <= '0;
          started_r <= 1'b0;
        end else begin
          phase_r   <= phase_nxt;
          acc_r     <= acc_nxt;
          dseen_r   <= dseen_nxt;
          pos_r     <= pos_nxt;
          first_r   <= first_nxt;
          lend_r    <= lend_nxt;
          started_r <= started_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_line_byte;
      s1_last_r <= in_last_byte;
    end
    if (fire && s1_last_r) begin
      if (phase_nxt == hslp_pkg::PH_MSG) begin
        res_ok_r    <= 1'b1;
        res_code_r  <= acc_nxt;
        res_start_r <= started_nxt ? first_nxt : pos_inc;
        res_end_r   <= started_nxt ? lend_nxt : pos_inc;
      end else begin
        res_ok_r    <= 1'b0;
        res_code_r  <= '0;
        res_start_r <= '0;
        res_end_r   <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_valid  = res_ok_r;
  assign out_status_code   = res_code_r;
  assign out_message_start = res_start_r;
  assign out_message_end   = res_end_r;

endmodule
